[sv/pif_pkg.sv]
// Shared types, codes and character helpers of the printf integer field formatter.
package pif_pkg;

  localparam int NDIG    = 22;
  localparam int DIG_W   = 4 * NDIG;
  localparam int OUT_CAP = 63;

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;
  localparam logic [2:0] KIND_PTR  = 3'd5;

  localparam logic [1:0] SIZE_WORD  = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_PLUS  = 8'h2b;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_LX    = 8'h78;
  localparam logic [7:0] ASCII_UX    = 8'h58;
  localparam logic [7:0] ALPHA_LO_OFS = 8'h57;
  localparam logic [7:0] ALPHA_UP_OFS = 8'h37;

  typedef enum logic [2:0] {
    SEL_SPACE,
    SEL_SIGN,
    SEL_PFX0,
    SEL_X,
    SEL_ZERO,
    SEL_DIGIT
  } chsel_t;

  typedef struct packed {
    logic   load;
    logic   conv;
    logic   scan;
    logic   calc1;
    logic   calc2;
    logic   emit;
    chsel_t sel;
  } pif_cmd_t;

  typedef struct packed {
    logic dec;
    logic conv_last;
    logic scan_done;
    logic left;
    logic has_sign;
    logic hdr_nz;
    logic hdr2;
    logic pad_nz;
    logic pad_one;
    logic zero_nz;
    logic zero_one;
    logic dig_one;
    logic emit_ok;
  } pif_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ASCII_ZERO + {4'b0, d};
    end else if (upper) begin
      ch = ALPHA_UP_OFS + {4'b0, d};
    end else begin
      ch = ALPHA_LO_OFS + {4'b0, d};
    end
    return ch;
  endfunction

endpackage

[sv/printf_integer_field_formatter.sv]
// Steps per item: load, decimal conversion by the shift-add-3 converter (passed over for octal and hex),
// leading-zero scan, sizing in the CALC1, CALC2 and PLAN states, then the first character is registered.
// Throughput: one character per cycle in the emission phase while the sink is ready.
// Reset: synchronous, active low; it clears the sequencer and the output valid.
// A new item is taken once the last character of the previous one sits in the output register.
module printf_integer_field_formatter import pif_pkg::*; #(
  parameter int FIELD_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // flag_left, flag_plus, flag_zero, flag_space, flag_alt,
                                  // size_mode[1:0], field_width[5:0], precision[5:0], value[63:0]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // ch[7:0]
  output logic        out_tlast
);

  pif_cmd_t cmd;
  pif_sts_t sts;

  pif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pif_dpath #(
    .FIELD_MAX (FIELD_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_ch    (out_tdata),
    .out_last  (out_tlast)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again in the cycle after a beat");

  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h20) && (out_tdata <= 8'h7a))
    else $error("output beat carries a character outside the field alphabet");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid set after reset");
`endif

endmodule

[sv/pif_ctrl.sv]
// Sequencer of the printf integer field formatter: conversion, scan, sizing and emission phases.
module pif_ctrl import pif_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pif_sts_t sts,
  output pif_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_CALC1,
    S_CALC2,
    S_PLAN,
    S_PADL,
    S_SIGN,
    S_PFX0,
    S_PFXX,
    S_ZERO,
    S_DIG,
    S_PADR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  state_t after_digs;
  state_t from_zeros;
  state_t from_pfx0;
  state_t from_sign;
  state_t from_padl;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    after_digs = (sts.left && sts.pad_nz) ? S_PADR : S_IDLE;
    from_zeros = sts.zero_nz ? S_ZERO : S_DIG;
    from_pfx0  = sts.hdr_nz ? S_PFX0 : from_zeros;
    from_sign  = sts.has_sign ? S_SIGN : from_pfx0;
    from_padl  = (!sts.left && sts.pad_nz) ? S_PADL : from_sign;
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_SPACE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (!sts.dec) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.conv = 1'b1;
          if (sts.conv_last) state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_CALC1;
        else cmd.scan = 1'b1;
      end
      S_CALC1: begin
        cmd.calc1 = 1'b1;
        state_nxt = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2 = 1'b1;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        state_nxt = from_padl;
      end
      S_PADL: begin
        cmd.sel  = SEL_SPACE;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok && sts.pad_one) state_nxt = from_sign;
      end
      S_SIGN: begin
        cmd.sel  = SEL_SIGN;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = from_pfx0;
      end
      S_PFX0: begin
        cmd.sel  = SEL_PFX0;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = sts.hdr2 ? S_PFXX : from_zeros;
      end
      S_PFXX: begin
        cmd.sel  = SEL_X;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = from_zeros;
      end
      S_ZERO: begin
        cmd.sel  = SEL_ZERO;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok && sts.zero_one) state_nxt = S_DIG;
      end
      S_DIG: begin
        cmd.sel  = SEL_DIGIT;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok && sts.dig_one) state_nxt = after_digs;
      end
      S_PADR: begin
        cmd.sel  = SEL_SPACE;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok && sts.pad_one) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/pif_dpath.sv]
// Datapath of the printf integer field formatter: operand prep, digit conversion, sizing and output register.
module pif_dpath import pif_pkg::*; #(
  parameter int FIELD_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pif_cmd_t    cmd,
  output pif_sts_t    sts,
  input  logic [2:0]  in_func,
  input  logic [87:0] in_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_ch,
  output logic        out_last
);

  localparam int LIMIT = (FIELD_MAX - 1 > OUT_CAP) ? OUT_CAP : FIELD_MAX - 1;
  localparam logic signed [7:0] LIMIT_S = 8'(LIMIT);
  localparam logic [5:0] LIMIT_U = 6'(LIMIT);

  // Input fields.
  logic        flag_left;
  logic        flag_plus;
  logic        flag_zero;
  logic        flag_space;
  logic        flag_alt;
  logic [1:0]  size_mode;
  logic [5:0]  field_width;
  logic [5:0]  precision;
  logic [63:0] value;

  assign flag_left   = in_data[0];
  assign flag_plus   = in_data[1];
  assign flag_zero   = in_data[2];
  assign flag_space  = in_data[3];
  assign flag_alt    = in_data[4];
  assign size_mode   = in_data[6:5];
  assign field_width = in_data[12:7];
  assign precision   = in_data[18:13];
  assign value       = in_data[82:19];

  // Operand preparation.
  logic             is_ptr;
  logic             is_sdec;
  logic             is_oct;
  logic             is_hex;
  logic             is_dec;
  logic             upper;
  logic [1:0]       size_eff;
  logic [63:0]      ext;
  logic             msb;
  logic             neg;
  logic [63:0]      mag;
  logic             left_eff;
  logic             zero_eff;
  logic [5:0]       prec_eff;
  logic [1:0]       hdr;
  logic             sign;
  logic [7:0]       sign_ch;
  logic [65:0]      m66;
  logic [DIG_W-1:0] dig_init;

  always_comb begin
    is_ptr  = (in_func == KIND_PTR);
    is_sdec = (in_func == KIND_SDEC);
    is_oct  = (in_func == KIND_OCT);
    is_hex  = (in_func == KIND_HEXL) || (in_func == KIND_HEXU) || is_ptr;
    is_dec  = !is_oct && !is_hex;
    upper   = (in_func == KIND_HEXU) || is_ptr;
    size_eff = is_ptr ? SIZE_WORD : size_mode;
    case (size_eff)
      SIZE_LONG: begin
        ext = value;
        msb = value[63];
      end
      SIZE_SHORT: begin
        msb = value[15];
        ext = (is_sdec && msb) ? {{48{1'b1}}, value[15:0]} : {48'b0, value[15:0]};
      end
      default: begin
        msb = value[31];
        ext = (is_sdec && msb) ? {{32{1'b1}}, value[31:0]} : {32'b0, value[31:0]};
      end
    endcase
    neg      = is_sdec && msb;
    mag      = neg ? (~ext + 64'd1) : ext;
    left_eff = flag_left && !is_ptr;
    zero_eff = flag_zero && !is_ptr && (precision == 6'd0);
    if (zero_eff && !left_eff) prec_eff = field_width;
    else if (is_ptr) prec_eff = 6'd8;
    else prec_eff = precision;
    if (flag_alt && (ext != 64'd0) && is_hex) hdr = 2'd2;
    else if (flag_alt && (ext != 64'd0) && is_oct) hdr = 2'd1;
    else hdr = 2'd0;
    sign = is_sdec && (neg || flag_plus || flag_space);
    if (neg) sign_ch = ASCII_MINUS;
    else if (flag_plus) sign_ch = ASCII_PLUS;
    else sign_ch = ASCII_SPACE;
    m66 = {2'b00, ext};
    dig_init = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (is_oct) dig_init[4*i +: 4] = {1'b0, m66[3*i +: 3]};
      else if (is_hex && i < 16) dig_init[4*i +: 4] = ext[4*i +: 4];
    end
  end

  // Stored operand and field layout.
  logic             dec_r;
  logic             upper_r;
  logic             left_r;
  logic             sign_r;
  logic [7:0]       sign_ch_r;
  logic [1:0]       hdr_r;
  logic [5:0]       prec_r;
  logic [5:0]       width_r;
  logic [63:0]      bin_r;
  logic [DIG_W-1:0] dig_r;
  logic [5:0]       step_r;
  logic [4:0]       ndig_r;
  logic [5:0]       zeros_r;
  logic [5:0]       pad_r;
  logic [5:0]       rem_r;
  logic             out_valid_r;
  logic [7:0]       out_ch_r;
  logic             out_last_r;

  // Binary to BCD step: add three to every digit of five or more, then shift.
  logic [DIG_W-1:0] adj;
  logic [DIG_W-1:0] dig_nxt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
    dig_nxt = {adj[DIG_W-2:0], bin_r[63]};
  end

  // Sizing of zero padding and space padding.
  logic [1:0]        hs;
  logic signed [7:0] p;
  logic signed [7:0] cap;
  logic signed [7:0] m;
  logic signed [7:0] d;
  logic [5:0]        zeros_nxt;
  logic [5:0]        w;
  logic [6:0]        len;
  logic [6:0]        wz;
  logic [6:0]        pad_nxt;
  logic [6:0]        total_nxt;

  always_comb begin
    hs  = hdr_r + {1'b0, sign_r};
    p   = $signed({2'b00, prec_r}) - $signed({6'b0, hs});
    cap = LIMIT_S - $signed({6'b0, hs});
    m   = (p < cap) ? p : cap;
    d   = m - $signed({3'b0, ndig_r});
    zeros_nxt = ((prec_r != 6'd0) && (d > 8'sd0)) ? d[5:0] : 6'd0;
    w   = (width_r > LIMIT_U) ? LIMIT_U : width_r;
    len = {2'b0, ndig_r} + {1'b0, zeros_r} + {5'b0, hs};
    wz  = {1'b0, w};
    pad_nxt   = (wz > len) ? wz - len : 7'd0;
    total_nxt = (wz > len) ? wz : len;
  end

  // Character of the current beat.
  logic [7:0] ch_nxt;

  always_comb begin
    case (cmd.sel)
      SEL_SPACE: ch_nxt = ASCII_SPACE;
      SEL_SIGN:  ch_nxt = sign_ch_r;
      SEL_PFX0:  ch_nxt = ASCII_ZERO;
      SEL_X:     ch_nxt = upper_r ? ASCII_UX : ASCII_LX;
      SEL_ZERO:  ch_nxt = ASCII_ZERO;
      SEL_DIGIT: ch_nxt = digit_char(dig_r[DIG_W-1 -: 4], upper_r);
      default:   ch_nxt = ASCII_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dec_r     <= is_dec;
      upper_r   <= upper;
      left_r    <= left_eff;
      sign_r    <= sign;
      sign_ch_r <= sign_ch;
      hdr_r     <= hdr;
      prec_r    <= prec_eff;
      width_r   <= field_width;
      bin_r     <= mag;
      dig_r     <= dig_init;
      step_r    <= 6'd0;
      ndig_r    <= 5'(NDIG);
    end else if (cmd.conv) begin
      dig_r  <= dig_nxt;
      bin_r  <= {bin_r[62:0], 1'b0};
      step_r <= step_r + 6'd1;
    end else if (cmd.scan) begin
      dig_r  <= dig_r << 4;
      ndig_r <= ndig_r - 5'd1;
    end
    if (cmd.calc1) zeros_r <= zeros_nxt;
    if (cmd.calc2) begin
      pad_r <= pad_nxt[5:0];
      rem_r <= total_nxt[5:0];
    end
    if (cmd.emit) begin
      out_ch_r   <= ch_nxt;
      out_last_r <= (rem_r == 6'd1);
      rem_r      <= rem_r - 6'd1;
      case (cmd.sel)
        SEL_SPACE: pad_r <= pad_r - 6'd1;
        SEL_ZERO:  zeros_r <= zeros_r - 6'd1;
        SEL_DIGIT: begin
          dig_r  <= dig_r << 4;
          ndig_r <= ndig_r - 5'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.dec       = dec_r;
    sts.conv_last = (step_r == 6'd63);
    sts.scan_done = (dig_r[DIG_W-1 -: 4] != 4'd0) || (ndig_r == 5'd1);
    sts.left      = left_r;
    sts.has_sign  = sign_r;
    sts.hdr_nz    = (hdr_r != 2'd0);
    sts.hdr2      = (hdr_r == 2'd2);
    sts.pad_nz    = (pad_r != 6'd0);
    sts.pad_one   = (pad_r == 6'd1);
    sts.zero_nz   = (zeros_r != 6'd0);
    sts.zero_one  = (zeros_r == 6'd1);
    sts.dig_one   = (ndig_r == 5'd1);
    sts.emit_ok   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

endmodule

[bench/field_format_checker.sv]
// Checker that predicts the formatted integer field of each input beat and compares the character stream.
`timescale 1ns / 1ps
module field_format_checker import pif_pkg::*; #(
  parameter int FIELD_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  field_char_t expected_chars[$];
  field_char_t want;

  task automatic predict_field(input logic [2:0] func, input logic [87:0] data);
    logic [4:0]  spare;
    logic [63:0] value;
    logic [5:0]  prec_f;
    logic [5:0]  width_f;
    logic [1:0]  size;
    logic        alt, space, zero, plus, left;
    logic        is_signed, upper, neg, has_sign;
    int unsigned radix;
    logic [63:0] mag;
    logic [7:0]  field[$];
    string       digs;
    int          hdr, prec, width, limit, pad, total, n;
    {spare, value, prec_f, width_f, size, alt, space, zero, plus, left} = data;
    limit = FIELD_MAX - 1;
    if (limit > OUT_CAP) limit = OUT_CAP;
    if (limit < 0) limit = 0;
    is_signed = (func == KIND_SDEC);
    upper = (func == KIND_HEXU) || (func == KIND_PTR);
    radix = 10;
    if (func == KIND_OCT) begin
      radix = 8;
    end else if (func == KIND_HEXL || func == KIND_HEXU || func == KIND_PTR) begin
      radix = 16;
    end
    digs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    prec = int'(prec_f);
    width = int'(width_f);
    if (!is_signed) begin
      plus = 1'b0;
      space = 1'b0;
    end
    if (func == KIND_PTR) begin
      left = 1'b0;
      zero = 1'b0;
      prec = 8;
      size = SIZE_WORD;
    end
    if (prec != 0) zero = 1'b0;
    neg = 1'b0;
    case (size)
      SIZE_LONG: begin
        mag = value;
        if (is_signed && value[63]) begin
          mag = -value;
          neg = 1'b1;
        end
      end
      SIZE_SHORT: begin
        mag = {48'b0, value[15:0]};
        if (is_signed && value[15]) begin
          mag = 64'h1_0000 - mag;
          neg = 1'b1;
        end
      end
      default: begin
        mag = {32'b0, value[31:0]};
        if (is_signed && value[31]) begin
          mag = 64'h1_0000_0000 - mag;
          neg = 1'b1;
        end
      end
    endcase
    do begin
      field.push_front(digs[int'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 0);
    hdr = 0;
    if (alt && radix != 10 && !is_signed && field[0] != ASCII_ZERO) hdr = (radix == 16) ? 2 : 1;
    has_sign = neg || plus || space;
    if (zero && !left) prec = width;
    if (prec != 0) begin
      if (has_sign) prec--;
      prec -= hdr;
      while (field.size() < prec && field.size() + hdr + int'(has_sign) < limit)
        field.push_front(ASCII_ZERO);
    end
    if (hdr == 2) field.push_front(upper ? ASCII_UX : ASCII_LX);
    if (hdr != 0) field.push_front(ASCII_ZERO);
    if (has_sign) field.push_front(neg ? ASCII_MINUS : (plus ? ASCII_PLUS : ASCII_SPACE));
    if (width > limit) width = limit;
    pad = (width > field.size()) ? width - field.size() : 0;
    repeat (pad) begin
      if (left) field.push_back(ASCII_SPACE);
      else field.push_front(ASCII_SPACE);
    end
    total = field.size();
    for (n = 0; n < total; n++) expected_chars.push_back('{ch: field[n], last: (n == total - 1)});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chars.delete();
      errors = 0;
    end else begin
      if (in_tvalid && in_tready) predict_field(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: ch %h last %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.ch) begin
            $error("ch mismatch: expected %h, actual %h", want.ch, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_tlast);
            errors++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

[bench/testbench.sv]
// Top of the formatter testbench: clock, reset, conversion stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module testbench;
  import pif_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 445;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_OFF     = 400;

  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [1:0] SIZE_SPARE  = 2'd3;

  localparam logic [4:0] NO_FLAGS  = 5'b00000;
  localparam logic [4:0] FL_LEFT   = 5'b00001;
  localparam logic [4:0] FL_PLUS   = 5'b00010;
  localparam logic [4:0] FL_ZERO   = 5'b00100;
  localparam logic [4:0] FL_SPACE  = 5'b01000;
  localparam logic [4:0] FL_ALT    = 5'b10000;
  localparam logic [4:0] ALL_FLAGS = 5'b11111;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  int          errors;
  int          pending;
  int          items_offered = 0;
  int          idle_cycles = 0;

  printf_integer_field_formatter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  field_format_checker field_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("printf_integer_field_formatter test failed");
      $finish;
    end
  end

  task automatic offer(input logic [2:0] func, input logic [4:0] flags, input logic [1:0] size,
                       input logic [5:0] width, input logic [5:0] prec, input logic [63:0] value);
    int gap;
    gap = ((items_offered % 64) < 12) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = func;
    in_tdata = {5'b0, value, prec, width, size, flags};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_offered++;
  endtask

  initial begin
    logic [2:0]  func;
    logic [4:0]  flags;
    logic [1:0]  size;
    logic [5:0]  width;
    logic [5:0]  prec;
    logic [63:0] value;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    offer(KIND_SDEC, NO_FLAGS, SIZE_WORD, 6'd0, 6'd0, 64'd0);
    offer(KIND_SDEC, NO_FLAGS, SIZE_WORD, 6'd15, 6'd0, 64'h8000_0000);
    offer(KIND_SDEC, FL_PLUS, SIZE_LONG, 6'd0, 6'd0, 64'h8000_0000_0000_0000);
    offer(KIND_SDEC, FL_ZERO, SIZE_SHORT, 6'd10, 6'd0, 64'h1234_8000);
    offer(KIND_SDEC, FL_PLUS | FL_SPACE | FL_LEFT, SIZE_WORD, 6'd8, 6'd0, 64'd42);
    offer(KIND_SDEC, FL_SPACE, SIZE_LONG, 6'd0, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    offer(KIND_UDEC, FL_PLUS | FL_SPACE, SIZE_LONG, 6'd63, 6'd63, ALL_ONES);
    offer(KIND_OCT, FL_ALT, SIZE_WORD, 6'd0, 6'd0, 64'd0);
    offer(KIND_OCT, FL_ALT, SIZE_WORD, 6'd0, 6'd5, 64'd8);
    offer(KIND_HEXL, FL_ALT | FL_ZERO, SIZE_WORD, 6'd20, 6'd0, 64'hDEAD_BEEF);
    offer(KIND_HEXU, FL_ALT | FL_LEFT, SIZE_LONG, 6'd40, 6'd0, ALL_ONES);
    offer(KIND_PTR, ALL_FLAGS, SIZE_LONG, 6'd30, 6'd3, 64'hFFFF_0000_0000_1234);
    offer(KIND_PTR, NO_FLAGS, SIZE_WORD, 6'd0, 6'd0, 64'd0);
    offer(KIND_SPARE6, FL_PLUS, SIZE_WORD, 6'd0, 6'd0, 64'hFFFF_FFFF);
    offer(KIND_SPARE7, FL_SPACE | FL_ALT, SIZE_WORD, 6'd12, 6'd0, 64'd99);
    offer(KIND_SDEC, NO_FLAGS, SIZE_SPARE, 6'd0, 6'd0, 64'hFFFF_FFFF_8000_0001);
    offer(KIND_SDEC, FL_ZERO | FL_LEFT, SIZE_WORD, 6'd12, 6'd0, 64'hFFFF_FFF6);
    offer(KIND_SDEC, NO_FLAGS, SIZE_WORD, 6'd0, 6'd4, 64'hFFFF_FFF9);
    offer(KIND_SDEC, FL_ZERO, SIZE_WORD, 6'd63, 6'd0, ALL_ONES);
    offer(KIND_SDEC, FL_PLUS, SIZE_LONG, 6'd0, 6'd63, 64'h8000_0000_0000_0001);
    offer(KIND_HEXL, FL_ZERO | FL_ALT, SIZE_WORD, 6'd16, 6'd6, 64'hABC);
    offer(KIND_UDEC, NO_FLAGS, SIZE_SHORT, 6'd0, 6'd0, 64'hFFFF_FFFF_FFFF_7FFF);
    offer(KIND_OCT, FL_ALT, SIZE_LONG, 6'd63, 6'd0, ALL_ONES);
    offer(KIND_UDEC, NO_FLAGS, SIZE_WORD, 6'd0, 6'd0, 64'd5);
    offer(KIND_HEXU, FL_ALT | FL_ZERO, SIZE_SHORT, 6'd63, 6'd0, 64'hFFFF);

    repeat (RANDOM_ITEMS) begin
      func = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
      flags = 5'($urandom_range(0, 31));
      size = ($urandom_range(0, 9) == 0) ? SIZE_SPARE : 2'($urandom_range(0, 2));
      width = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16));
      case ($urandom_range(0, 19))
        0, 1, 2: prec = 6'($urandom_range(0, 63));
        3, 4, 5, 6, 7, 8, 9: prec = 6'($urandom_range(1, 12));
        default: prec = 6'd0;
      endcase
      case ($urandom_range(0, 5))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(0, 20));
        2: value = {32'h0, $urandom};
        3: value = ALL_ONES - $urandom_range(0, 3);
        4: value = 64'd1 << $urandom_range(0, 63);
        default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      offer(func, flags, size, width, prec, value);
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("printf_integer_field_formatter test passed");
    end else begin
      $display("printf_integer_field_formatter test failed");
    end
    $finish;
  end

  // Once in a while the sink holds off long enough that the formatter backs up into its input.
  initial begin
    int stall;
    int beats;
    beats = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    forever begin
      if (beats % 3000 == 600) begin
        stall = HOLD_OFF;
      end else if (beats % 256 < 48) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
      beats++;
    end
  end

endmodule
